### design/motor_feedback_frame_decoder_macros.svh
// Assertion macros shared by the motor feedback frame decoder modules.
`ifndef MOTOR_FEEDBACK_FRAME_DECODER_MACROS_SVH
`define MOTOR_FEEDBACK_FRAME_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MFFD_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mffd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MFFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mffd: next-cycle check failed");

`endif

### design/mffd_pkg.sv
// Types and constants of the motor feedback frame decoder.
package mffd_pkg;

  // Stream word layout
  localparam int unsigned EidW    = 29;
  localparam int unsigned LenW    = 4;
  localparam int unsigned BytesW  = 64;
  localparam int unsigned IdW     = 8;
  localparam int unsigned InDataW = 112;   // 105 bits of fields, padded to bytes
  localparam int unsigned OutDataW = 200;  // 197 bits of fields, padded to bytes
  localparam int unsigned IdsW    = 48;
  localparam int unsigned CfgJoints = 6;   // joints that own a byte of the id register
  localparam int unsigned JointIdxW = 3;

  localparam logic [IdsW-1:0] IdsReset = 48'h0605_0403_0201;

  // Frame bytes and function codes
  localparam logic [7:0] CheckByte    = 8'h6B;
  localparam logic [7:0] FnProtection = 8'h13;
  localparam logic [7:0] FnCurrent    = 8'h27;
  localparam logic [7:0] FnVelocity   = 8'h35;
  localparam logic [7:0] FnPosition   = 8'h36;
  localparam logic [7:0] FnStatus     = 8'h3A;
  localparam logic [7:0] FnCombined   = 8'h3C;
  localparam logic [7:0] AckA         = 8'h02;
  localparam logic [7:0] AckB         = 8'h12;
  localparam logic [7:0] AckC         = 8'h9F;
  localparam logic [7:0] AckD         = 8'hE2;
  localparam logic [7:0] AckE         = 8'hEE;

  // Position scaling: urad = tenths * UradPerPi / TenthsPerPi
  localparam longint unsigned UradPerPi   = 64'd3141593;
  localparam longint unsigned TenthsPerPi = 64'd1800;
  localparam longint unsigned ScaleInt    = UradPerPi / TenthsPerPi;   // 1745
  localparam longint unsigned ScaleFrac   = UradPerPi % TenthsPerPi;   // 593
  // Smallest magnitude whose scaled value reaches 2^31
  localparam longint unsigned SatMag =
    ((64'd1 << 31) * TenthsPerPi + UradPerPi - 64'd1) / UradPerPi;
  localparam int unsigned MagW   = 21;   // magnitudes below SatMag fit here
  localparam int unsigned AW     = 32;   // ScaleInt * mag
  localparam int unsigned XW     = 31;   // ScaleFrac * mag
  localparam int unsigned DivShift = 3;  // TenthsPerPi = 8 * DivRest
  localparam longint unsigned DivRest = TenthsPerPi >> DivShift;       // 225
  localparam int unsigned YW     = XW - DivShift;
  localparam int unsigned RecipShift = 36;
  localparam int unsigned RecipW = 29;
  localparam longint unsigned Recip = (64'd1 << RecipShift) / DivRest;
  localparam int unsigned QW     = 21;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_FIX,
    ST_WRITE
  } state_e;

  typedef enum logic [3:0] {
    OP_REJECT,
    OP_QUERY,
    OP_ACK,
    OP_PROT,
    OP_CUR,
    OP_VEL,
    OP_POS,
    OP_STAT,
    OP_COMB
  } op_e;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;
    logic decode;
    logic div;
    logic fix;
    logic commit;
  } cmd_t;

  // Feedback record of one joint
  typedef struct packed {
    logic [31:0] prot_samples;
    logic [31:0] pos_samples;
    logic [15:0] prot_time;
    logic [15:0] prot_current;
    logic [15:0] prot_temp;
    logic [15:0] status;
    logic [15:0] current;
    logic [16:0] velocity;
    logic [31:0] position;
    logic        online;
  } rec_t;

endpackage

### design/mffd_ctrl.sv
// Sequencing state machine of the motor feedback frame decoder.
`include "motor_feedback_frame_decoder_macros.svh"

module mffd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_blocked_i,
  output mffd_pkg::cmd_t cmd_o
);

  mffd_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mffd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mffd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mffd_pkg::ST_DECODE;
        end
      end
      mffd_pkg::ST_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = mffd_pkg::ST_DIV;
      end
      mffd_pkg::ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = mffd_pkg::ST_FIX;
      end
      mffd_pkg::ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = mffd_pkg::ST_WRITE;
      end
      mffd_pkg::ST_WRITE: begin
        // wait while the previous result word is still held
        if (!out_blocked_i) begin
          cmd_o.commit = 1'b1;
          state_d      = mffd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mffd_pkg::ST_IDLE;
      end
    endcase
  end

  `MFFD_ASSERT_SAME(a_commit_free, clk_i, rst_ni, cmd_o.commit, !out_blocked_i)
  `MFFD_ASSERT_NEXT(a_commit_idle, clk_i, rst_ni, cmd_o.commit, in_ready_o)
  `MFFD_ASSERT_NEXT(a_load_decode, clk_i, rst_ni, cmd_o.load, cmd_o.decode && !in_ready_o)

endmodule

### design/mffd_datapath.sv
// Frame check, joint lookup, position scaling and record store.
`include "motor_feedback_frame_decoder_macros.svh"

module mffd_datapath #(
  parameter int unsigned JOINTS = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mffd_pkg::cmd_t                 cmd_i,
  input  logic [mffd_pkg::InDataW-1:0]   in_data_i,
  input  logic                           in_kind_i,
  input  logic                           cfg_we_i,
  input  logic [mffd_pkg::IdsW-1:0]      cfg_wdata_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mffd_pkg::OutDataW-1:0]  out_data_o,
  output logic                           out_accepted_o,
  output logic                           out_blocked_o
);

  localparam int unsigned JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  // Joint id register
  logic [mffd_pkg::IdsW-1:0] ids_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ids_q <= mffd_pkg::IdsReset;
    end else if (cfg_we_i) begin
      ids_q <= cfg_wdata_i;
    end
  end

  // Input word register
  logic                         kind_q;
  logic [mffd_pkg::EidW-1:0]    eid_q;
  logic [mffd_pkg::LenW-1:0]    len_q;
  logic [mffd_pkg::BytesW-1:0]  bytes_q;
  logic [mffd_pkg::IdW-1:0]     qid_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= in_kind_i;
      eid_q   <= in_data_i[28:0];
      len_q   <= in_data_i[32:29];
      bytes_q <= in_data_i[96:33];
      qid_q   <= in_data_i[104:97];
    end
  end

  logic [7:0] d [8];
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      d[i] = bytes_q[63 - 8*i -: 8];
    end
  end

  // Frame checks and function decode
  logic        len_ok, frame_ok, ack, sign_ok;
  logic [7:0]  last_byte, look_id;
  mffd_pkg::op_e op_d;
  always_comb begin
    len_ok    = (len_q >= 4'd3) && (len_q <= 4'd8);
    last_byte = d[len_q[2:0] - 3'd1];   // length 8 wraps to byte 7
    frame_ok  = len_ok && (eid_q[7:0] == 8'h00) && (eid_q[28:16] == '0)
                && (last_byte == mffd_pkg::CheckByte);
    sign_ok   = d[1] <= 8'd1;
    ack       = (len_q == 4'd3) && (d[0] != mffd_pkg::FnStatus)
                && ((d[1] == mffd_pkg::AckA) || (d[1] == mffd_pkg::AckB)
                 || (d[1] == mffd_pkg::AckC) || (d[1] == mffd_pkg::AckD)
                 || (d[1] == mffd_pkg::AckE));
    look_id   = kind_q ? qid_q : eid_q[15:8];
    op_d      = mffd_pkg::OP_REJECT;
    if (kind_q) begin
      op_d = mffd_pkg::OP_QUERY;
    end else if (frame_ok) begin
      if (ack) begin
        op_d = mffd_pkg::OP_ACK;
      end else begin
        case (d[0])
          mffd_pkg::FnProtection: if (len_q == 4'd8) op_d = mffd_pkg::OP_PROT;
          mffd_pkg::FnCurrent:    if (len_q == 4'd4) op_d = mffd_pkg::OP_CUR;
          mffd_pkg::FnVelocity:   if (len_q == 4'd5 && sign_ok) op_d = mffd_pkg::OP_VEL;
          mffd_pkg::FnPosition:   if (len_q == 4'd7 && sign_ok) op_d = mffd_pkg::OP_POS;
          mffd_pkg::FnStatus:     if (len_q == 4'd3) op_d = mffd_pkg::OP_STAT;
          mffd_pkg::FnCombined:   if (len_q == 4'd4) op_d = mffd_pkg::OP_COMB;
          default:                op_d = mffd_pkg::OP_REJECT;
        endcase
      end
    end
  end

  // Joint lookup, lowest matching joint wins
  logic [63:0]   ids_ext;
  logic          hit_d;
  logic [JW-1:0] joint_d;
  always_comb begin
    ids_ext = {16'h0000, ids_q};
    hit_d   = 1'b0;
    joint_d = '0;
    for (int j = JOINTS - 1; j >= 0; j--) begin
      if (((j < mffd_pkg::CfgJoints) ? ids_ext[8*j +: 8] : 8'h00) == look_id) begin
        hit_d   = 1'b1;
        joint_d = JW'(j);
      end
    end
  end

  // Position scaling, first stage: integer and fractional parts of the factor
  logic [31:0]              mag;
  logic [mffd_pkg::MagW-1:0] mag_s;
  assign mag   = {d[2], d[3], d[4], d[5]};
  assign mag_s = mag[mffd_pkg::MagW-1:0];

  mffd_pkg::op_e            op_q;
  logic                     hit_q, sat_q, neg_q;
  logic [JW-1:0]            joint_q;
  logic [mffd_pkg::AW-1:0]  a_q;
  logic [mffd_pkg::XW-1:0]  x_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      op_q    <= op_d;
      hit_q   <= hit_d;
      joint_q <= joint_d;
      sat_q   <= {32'h0, mag} >= mffd_pkg::SatMag;
      neg_q   <= d[1] == 8'd1;
      a_q     <= mffd_pkg::AW'({11'h0, mag_s} * 32'(mffd_pkg::ScaleInt));
      x_q     <= mffd_pkg::XW'({10'h0, mag_s} * 31'(mffd_pkg::ScaleFrac));
    end
  end

  // Second stage: quotient estimate by reciprocal multiply
  logic [mffd_pkg::YW-1:0]                  y;
  logic [mffd_pkg::YW+mffd_pkg::RecipW-1:0] y_prod;
  logic [mffd_pkg::QW-1:0]                  q0_q;
  assign y      = x_q[mffd_pkg::XW-1:mffd_pkg::DivShift];
  assign y_prod = {{mffd_pkg::RecipW{1'b0}}, y}
                  * (mffd_pkg::YW + mffd_pkg::RecipW)'(mffd_pkg::Recip);
  always_ff @(posedge clk_i) begin
    if (cmd_i.div) begin
      q0_q <= y_prod[mffd_pkg::RecipShift +: mffd_pkg::QW];
    end
  end

  // Third stage: estimate is exact or one low; correct and add integer part
  logic [mffd_pkg::YW-1:0] rem;
  logic [mffd_pkg::QW-1:0] q;
  logic [31:0]             u_q;
  assign rem = y - mffd_pkg::YW'({7'h0, q0_q} * 28'(mffd_pkg::DivRest));
  assign q   = q0_q + mffd_pkg::QW'(rem >= mffd_pkg::YW'(mffd_pkg::DivRest));
  always_ff @(posedge clk_i) begin
    if (cmd_i.fix) begin
      u_q <= a_q + 32'(q);
    end
  end

  // Record store
  mffd_pkg::rec_t rec_q [JOINTS];
  mffd_pkg::rec_t rec_cur, rec_nxt;
  logic [31:0]    pos_val;
  logic [16:0]    vel_mag;
  logic           acc, wr_rec;
  always_comb begin
    rec_cur = rec_q[joint_q];
    rec_nxt = rec_cur;
    vel_mag = {1'b0, d[2], d[3]};
    if (sat_q) begin
      pos_val = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      pos_val = neg_q ? 32'(-u_q) : u_q;
    end
    case (op_q)
      mffd_pkg::OP_PROT: begin
        rec_nxt.prot_temp    = {d[1], d[2]};
        rec_nxt.prot_current = {d[3], d[4]};
        rec_nxt.prot_time    = {d[5], d[6]};
        rec_nxt.prot_samples = rec_cur.prot_samples + 32'd1;
      end
      mffd_pkg::OP_CUR:  rec_nxt.current = {d[1], d[2]};
      mffd_pkg::OP_VEL:  rec_nxt.velocity = neg_q ? 17'(-vel_mag) : vel_mag;
      mffd_pkg::OP_POS: begin
        rec_nxt.position    = pos_val;
        rec_nxt.pos_samples = rec_cur.pos_samples + 32'd1;
      end
      mffd_pkg::OP_STAT: rec_nxt.status[7:0] = d[1];
      mffd_pkg::OP_COMB: rec_nxt.status = {d[1], d[2]};
      default: ;
    endcase
    if (op_q != mffd_pkg::OP_QUERY) begin
      rec_nxt.online = 1'b1;
    end
    acc    = hit_q && (op_q != mffd_pkg::OP_REJECT);
    wr_rec = acc && (op_q != mffd_pkg::OP_QUERY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < JOINTS; k++) begin
        rec_q[k] <= '0;
      end
    end else if (cmd_i.commit && wr_rec) begin
      rec_q[joint_q] <= rec_nxt;
    end
  end

  // Output word register
  logic                          out_valid_q;
  logic                          out_acc_q;
  logic [mffd_pkg::OutDataW-1:0] out_data_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_acc_q  <= acc;
      out_data_q <= acc ? {3'b000, rec_nxt, mffd_pkg::JointIdxW'(joint_q)} : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign out_accepted_o = out_acc_q;
  assign out_blocked_o  = out_valid_q && !out_ready_i;

  `MFFD_ASSERT_SAME(a_reject_zero, clk_i, rst_ni, out_valid_q && !out_acc_q, out_data_q == '0)
  `MFFD_ASSERT_NEXT(a_commit_shows, clk_i, rst_ni, cmd_i.commit, out_valid_q)

endmodule

### design/motor_feedback_frame_decoder.sv
// Motor feedback frame decoder: checks motor reply frames, updates the
// per-joint feedback record and returns it, or reads a record by motor id.
// Every input word yields exactly one result word. After the accepting
// edge the word passes decode and lookup, reciprocal multiply, quotient
// correction and the record write, and the result word is registered on
// the output. The position scaling has three registered stages. Items are
// handled one at a time: a new word is taken only once the last one has
// been written. The record write waits while the previous result word is
// still held on the output, which also delays the next accept. A new word
// is accepted while the previous result still waits on the output. All
// records are cleared by reset; no clearing pass is needed.
module motor_feedback_frame_decoder #(
  parameter int unsigned JOINTS = 6
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration: joint motor ids, joint 0 in bits 7:0
  input  logic         cfg_we_i,
  input  logic [47:0]  cfg_wdata_i,
  // input words
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [28:0] frame_id, [32:29] frame_length, [96:33] frame_bytes,
  // [104:97] query_motor_id, [111:105] zero
  input  logic [111:0] s_axis_tdata,
  // [0] kind
  input  logic         s_axis_tuser,
  // result words
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] joint_num, [3] online, [35:4] position, [52:36] velocity,
  // [68:53] phase_current, [84:69] status_word, [100:85] prot_temperature,
  // [116:101] prot_current, [132:117] prot_time, [164:133] position_samples,
  // [196:165] protection_samples, [199:197] zero
  output logic [199:0] m_axis_tdata,
  // [0] accepted
  output logic         m_axis_tuser
);

  mffd_pkg::cmd_t cmd;
  logic           out_blocked;

  mffd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .out_blocked_i (out_blocked),
    .cmd_o         (cmd)
  );

  mffd_datapath #(
    .JOINTS (JOINTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_data_i      (s_axis_tdata),
    .in_kind_i      (s_axis_tuser),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata),
    .out_accepted_o (m_axis_tuser),
    .out_blocked_o  (out_blocked)
  );

endmodule

### tb/motor_feedback_frame_decoder_record_check.sv
// Result checker for the motor feedback frame decoder: mirrors joint records, compares words.
`timescale 1ns / 100ps

module motor_feedback_frame_decoder_record_check #(
  parameter int unsigned NumJoints = 6
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [47:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [199:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  output int unsigned  mismatches_o,
  output int unsigned  pending_o
);

  // One predicted result word
  typedef struct packed {
    logic           accepted;
    logic [2:0]     joint;
    mffd_pkg::rec_t rec;
  } feedback_t;

  logic [mffd_pkg::IdsW-1:0] motor_ids;
  mffd_pkg::rec_t            records [NumJoints];
  feedback_t                 expected_q [$];

  // First joint whose configured id equals the address, -1 if none
  function automatic int lookup_joint(logic [20:0] addr);
    logic [7:0] cfg;
    for (int j = 0; j < NumJoints; j++) begin
      cfg = (j < mffd_pkg::CfgJoints) ? motor_ids[8*j +: 8] : 8'h00;
      if ({13'd0, cfg} == addr) return j;
    end
    return -1;
  endfunction

  // Tenths of a degree to microradians, clamped to the signed 32-bit range
  function automatic logic [31:0] scale_to_urad(logic [31:0] mag, logic neg);
    longint unsigned scaled;
    scaled = (64'(mag) * mffd_pkg::UradPerPi) / mffd_pkg::TenthsPerPi;
    if (neg) begin
      if (scaled >= 64'h8000_0000) return 32'h8000_0000;
      return ~scaled[31:0] + 32'd1;
    end
    if (scaled > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return scaled[31:0];
  endfunction

  // Validate a reply frame and fold it into the joint record; -1 on reject
  function automatic int apply_reply(logic [28:0] eid, logic [3:0] len, logic [63:0] bytes);
    logic [7:0]  b [8];
    logic [31:0] m;
    int          j;
    if (len < 3 || len > 8 || eid[7:0] != 8'h00) return -1;
    for (int i = 0; i < 8; i++) b[i] = bytes[56-8*i +: 8];
    if (b[len - 1] != mffd_pkg::CheckByte) return -1;
    if (eid[28:8] > 21'h0000FF) return -1;
    j = lookup_joint(eid[28:8]);
    if (j < 0) return -1;
    // short acknowledge only marks the joint online
    if (len == 3 && b[0] != mffd_pkg::FnStatus
        && (b[1] inside {mffd_pkg::AckA, mffd_pkg::AckB, mffd_pkg::AckC,
                         mffd_pkg::AckD, mffd_pkg::AckE})) begin
      records[j].online = 1'b1;
      return j;
    end
    case (b[0])
      mffd_pkg::FnProtection: begin
        if (len != 8) return -1;
        records[j].prot_temp    = {b[1], b[2]};
        records[j].prot_current = {b[3], b[4]};
        records[j].prot_time    = {b[5], b[6]};
        records[j].prot_samples = records[j].prot_samples + 32'd1;
      end
      mffd_pkg::FnCurrent: begin
        if (len != 4) return -1;
        records[j].current = {b[1], b[2]};
      end
      mffd_pkg::FnVelocity: begin
        if (len != 5 || b[1] > 8'd1) return -1;
        m = {16'd0, b[2], b[3]};
        if (b[1] == 8'd1) m = 32'd0 - m;
        records[j].velocity = m[16:0];
      end
      mffd_pkg::FnPosition: begin
        if (len != 7 || b[1] > 8'd1) return -1;
        m = {b[2], b[3], b[4], b[5]};
        records[j].position    = scale_to_urad(m, b[1] == 8'd1);
        records[j].pos_samples = records[j].pos_samples + 32'd1;
      end
      mffd_pkg::FnStatus: begin
        if (len != 3) return -1;
        records[j].status = {records[j].status[15:8], b[1]};
      end
      mffd_pkg::FnCombined: begin
        if (len != 4) return -1;
        records[j].status = {b[1], b[2]};
      end
      default: return -1;
    endcase
    records[j].online = 1'b1;
    return j;
  endfunction

  // Expected result word for one accepted input word
  function automatic feedback_t predict_feedback(logic kind, logic [111:0] word);
    feedback_t res;
    int        j;
    res = '0;
    if (kind) j = lookup_joint({13'd0, word[104:97]});
    else      j = apply_reply(word[28:0], word[32:29], word[96:33]);
    if (j >= 0) begin
      res.accepted = 1'b1;
      res.joint    = 3'(j);
      res.rec      = records[j];
    end
    return res;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches_o++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic compare_feedback(feedback_t want);
    mffd_pkg::rec_t got;
    got = mffd_pkg::rec_t'(m_axis_tdata[196:3]);
    compare_field("accepted", 32'(want.accepted), 32'(m_axis_tuser));
    compare_field("joint_num", 32'(want.joint), 32'(m_axis_tdata[2:0]));
    compare_field("padding", 32'd0, 32'(m_axis_tdata[199:197]));
    compare_field("online", 32'(want.rec.online), 32'(got.online));
    compare_field("position", want.rec.position, got.position);
    compare_field("velocity", 32'(want.rec.velocity), 32'(got.velocity));
    compare_field("phase_current", 32'(want.rec.current), 32'(got.current));
    compare_field("status_word", 32'(want.rec.status), 32'(got.status));
    compare_field("prot_temperature", 32'(want.rec.prot_temp), 32'(got.prot_temp));
    compare_field("prot_current", 32'(want.rec.prot_current), 32'(got.prot_current));
    compare_field("prot_time", 32'(want.rec.prot_time), 32'(got.prot_time));
    compare_field("position_samples", want.rec.pos_samples, got.pos_samples);
    compare_field("protection_samples", want.rec.prot_samples, got.prot_samples);
  endtask

  // Track config, retire results, then queue the prediction for a new word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_ids    = mffd_pkg::IdsReset;
      for (int j = 0; j < NumJoints; j++) records[j] = '0;
      expected_q.delete();
      mismatches_o = 0;
    end else begin
      if (cfg_we_i) motor_ids = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          mismatches_o++;
          $display("%0t: result word expected none actual %0h", $time, m_axis_tdata);
        end else begin
          compare_feedback(expected_q.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(predict_feedback(s_axis_tuser, s_axis_tdata));
    end
    pending_o = expected_q.size();
  end

endmodule

### tb/motor_feedback_frame_decoder_tb.sv
// Testbench top for the motor feedback frame decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module motor_feedback_frame_decoder_tb;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [47:0]  cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;   // [28:0] eid, [32:29] len, [96:33] bytes, [104:97] query id
  logic         s_axis_tuser;   // [0] kind
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [199:0] m_axis_tdata;   // [2:0] joint, [196:3] record, [199:197] zero
  logic         m_axis_tuser;   // [0] accepted

  int unsigned  mismatches;
  int unsigned  pending;
  logic [47:0]  ids_cfg;        // copy of the id register, used to aim frames
  bit           tx_steady;
  bit           rx_steady;

  always #5 clk_i = ~clk_i;

  motor_feedback_frame_decoder dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  motor_feedback_frame_decoder_record_check u_record_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .mismatches_o(mismatches), .pending_o(pending)
  );

  // Present one word after a random gap and hold it until taken
  task automatic send_word(logic kind, logic [28:0] eid, logic [3:0] len, logic [63:0] w,
                           logic [7:0] qid);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'd0, qid, w, len, eid};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Well-formed frame (or query) for one operation, random filler elsewhere
  task automatic make_frame(input mffd_pkg::op_e op, input logic [7:0] mid,
                            input logic [31:0] value, input logic neg,
                            output logic kind, output logic [28:0] eid,
                            output logic [3:0] len, output logic [63:0] w,
                            output logic [7:0] qid);
    logic [7:0] ack_codes [5];
    ack_codes = '{mffd_pkg::AckA, mffd_pkg::AckB, mffd_pkg::AckC,
                  mffd_pkg::AckD, mffd_pkg::AckE};
    kind = (op == mffd_pkg::OP_QUERY);
    eid  = {13'd0, mid, 8'd0};
    qid  = (op == mffd_pkg::OP_QUERY) ? mid : 8'($urandom);
    w    = {$urandom, $urandom};
    len  = 4'd3;
    case (op)
      mffd_pkg::OP_ACK: begin
        w[63:56] = (value[15:8] == mffd_pkg::FnStatus) ? mffd_pkg::FnCurrent : value[15:8];
        w[55:48] = ack_codes[value[7:0] % 5];
      end
      mffd_pkg::OP_PROT: begin
        len = 4'd8;  w[63:56] = mffd_pkg::FnProtection;  w[55:24] = value;
      end
      mffd_pkg::OP_CUR: begin
        len = 4'd4;  w[63:56] = mffd_pkg::FnCurrent;  w[55:40] = value[15:0];
      end
      mffd_pkg::OP_VEL: begin
        len = 4'd5;  w[63:56] = mffd_pkg::FnVelocity;  w[55:48] = {7'd0, neg};
        w[47:32] = value[15:0];
      end
      mffd_pkg::OP_POS: begin
        len = 4'd7;  w[63:56] = mffd_pkg::FnPosition;  w[55:48] = {7'd0, neg};
        w[47:16] = value;
      end
      mffd_pkg::OP_STAT: begin
        w[63:56] = mffd_pkg::FnStatus;  w[55:48] = value[7:0];
      end
      mffd_pkg::OP_COMB: begin
        len = 4'd4;  w[63:56] = mffd_pkg::FnCombined;  w[55:40] = value[15:0];
      end
      default: ;
    endcase
    w[8*(8-len) +: 8] = mffd_pkg::CheckByte;
  endtask

  task automatic send_op(mffd_pkg::op_e op, logic [7:0] mid, logic [31:0] value, logic neg);
    logic        kind;
    logic [28:0] eid;
    logic [3:0]  len;
    logic [63:0] w;
    logic [7:0]  qid;
    make_frame(op, mid, value, neg, kind, eid, len, w, qid);
    send_word(kind, eid, len, w, qid);
  endtask

  // Mostly a configured id, sometimes any id
  function automatic logic [7:0] pick_motor_id();
    if ($urandom_range(0, 6) == 0) return 8'($urandom_range(0, 255));
    return ids_cfg[8*$urandom_range(0, 5) +: 8];
  endfunction

  function automatic mffd_pkg::op_e random_op();
    return mffd_pkg::op_e'($urandom_range(mffd_pkg::OP_ACK, mffd_pkg::OP_COMB));
  endfunction

  // Payload value with weight on extremes and the position clamp boundary
  function automatic logic [31:0] draw_value(mffd_pkg::op_e op);
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return (op == mffd_pkg::OP_POS)
                ? 32'(mffd_pkg::SatMag) - 32'd64 + $urandom_range(0, 127) : $urandom;
      3: return $urandom_range(0, 20000);
      default: return $urandom;
    endcase
  endfunction

  // Well-formed frame with one defect, or plain garbage
  task automatic send_noise();
    logic          kind;
    logic [28:0]   eid;
    logic [3:0]    len;
    logic [63:0]   w;
    logic [7:0]    qid;
    mffd_pkg::op_e op;
    op = random_op();
    make_frame(op, pick_motor_id(), $urandom, 1'($urandom), kind, eid, len, w, qid);
    case ($urandom_range(0, 6))
      0: begin
        kind = 1'($urandom);  eid = 29'($urandom);  len = 4'($urandom);
        w = {$urandom, $urandom};
      end
      1: w[8*(8-len) +: 8] ^= 8'($urandom_range(1, 255));
      2: begin
        len = 4'($urandom);
        if (len >= 3 && len <= 8) w[8*(8-len) +: 8] = mffd_pkg::CheckByte;
      end
      3: eid[7:0]   = 8'($urandom_range(1, 255));
      4: eid[28:16] = 13'($urandom_range(1, 8191));
      5: w[55:48]   = 8'($urandom_range(2, 255));
      default: w[63:56] = 8'($urandom);
    endcase
    send_word(kind, eid, len, w, qid);
  endtask

  // Reprogram the ids once the decoder has drained
  task automatic write_motor_ids(logic [47:0] ids);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ids;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    ids_cfg = ids;
  endtask

  // Result side: random stalls with steady stretches
  initial begin : result_sink
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 5);
      @(negedge clk_i);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : stimulus
    logic [47:0]   ids;
    mffd_pkg::op_e op;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    ids_cfg       = mffd_pkg::IdsReset;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset ids, one of each reply, clamp edges, bad lengths
    send_op(mffd_pkg::OP_QUERY, 8'd1, '0, 1'b0);      // record before any reply
    send_op(mffd_pkg::OP_QUERY, 8'd0, '0, 1'b0);      // id owned by no joint
    for (int k = 0; k < 5; k++)
      send_op(mffd_pkg::OP_ACK, 8'(k + 1), {16'd0, 8'($urandom), 8'(k)}, 1'b0);
    // status code wins over ack byte
    send_op(mffd_pkg::OP_STAT, 8'd6, {24'd0, mffd_pkg::AckC}, 1'b0);
    send_op(mffd_pkg::OP_PROT, 8'd1, '1, 1'b0);
    send_op(mffd_pkg::OP_PROT, 8'd2, '0, 1'b0);
    send_op(mffd_pkg::OP_CUR, 8'd3, 32'hFFFF, 1'b0);
    send_op(mffd_pkg::OP_VEL, 8'd4, 32'hFFFF, 1'b0);
    send_op(mffd_pkg::OP_VEL, 8'd4, 32'hFFFF, 1'b1);
    send_op(mffd_pkg::OP_POS, 8'd1, '1, 1'b0);
    send_op(mffd_pkg::OP_POS, 8'd1, '1, 1'b1);
    send_op(mffd_pkg::OP_POS, 8'd5, 32'(mffd_pkg::SatMag) - 32'd1, 1'b0);
    send_op(mffd_pkg::OP_POS, 8'd5, 32'(mffd_pkg::SatMag), 1'b0);
    send_op(mffd_pkg::OP_POS, 8'd6, 32'(mffd_pkg::SatMag) - 32'd1, 1'b1);
    send_op(mffd_pkg::OP_POS, 8'd6, '0, 1'b1);
    send_op(mffd_pkg::OP_COMB, 8'd2, 32'hFFFF, 1'b0);
    send_op(mffd_pkg::OP_STAT, 8'd2, 32'h0, 1'b0);    // low status byte only
    send_op(mffd_pkg::OP_QUERY, 8'd2, '0, 1'b0);
    send_word(1'b0, 29'h100, 4'd9, {8{mffd_pkg::CheckByte}}, 8'd0);
    send_word(1'b0, 29'h100, 4'd0, '1, 8'd0);
    send_word(1'b0, 29'h100, 4'd15, {8{mffd_pkg::CheckByte}}, 8'd0);

    // Random phases; each phase but the first writes a new id map
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        1: write_motor_ids(48'hFFFF_FFFF_FFFF);   // every joint shares one id
        2: write_motor_ids(48'h0000_0000_0000);
        3: write_motor_ids(48'h0102_0304_0506);
        4: write_motor_ids({16'($urandom), $urandom});
        5: begin
          ids = {16'($urandom), $urandom};
          ids[47:40] = ids[15:8];
          ids[31:24] = ids[7:0];
          write_motor_ids(ids);
        end
        6: write_motor_ids(mffd_pkg::IdsReset);
        default: ;
      endcase
      repeat (250) begin
        if ($urandom_range(0, 3) == 0) begin
          send_noise();
        end else begin
          op = ($urandom_range(0, 6) == 0) ? mffd_pkg::OP_QUERY : random_op();
          send_op(op, pick_motor_id(), draw_value(op), 1'($urandom));
        end
      end
    end

    // Drain and decide
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0)
      $display("** motor_feedback_frame_decoder: PASSED **");
    else
      $display("** motor_feedback_frame_decoder: FAILED **");
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #5_000_000;
    $display("** motor_feedback_frame_decoder: FAILED **");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/mffd_pkg.sv
design/mffd_ctrl.sv
design/mffd_datapath.sv
design/motor_feedback_frame_decoder.sv
tb/motor_feedback_frame_decoder_record_check.sv
tb/motor_feedback_frame_decoder_tb.sv
